// ----- rtl/core/sobel_edge_median_threshold_defines.svh -----
// assertion macros used by the checker file of the block
`ifndef SOBEL_EDGE_MEDIAN_THRESHOLD_DEFINES_SVH
`define SOBEL_EDGE_MEDIAN_THRESHOLD_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SEMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SEMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/semt_pkg.sv -----
`default_nettype none

package semt_pkg;

    // line store depth and derived widths
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);

    // register fields
    localparam int FW_W     = 12;
    localparam int FH_W     = 16;
    localparam int FW_RESET = 640;
    localparam int FH_RESET = 480;
    localparam int MIN_DIM  = 3;

    // width wide enough for column counts and the clamped frame width
    localparam int CNT_W = (FW_W > COL_W + 1) ? FW_W : COL_W + 1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    // pixel and result widths
    localparam int PIX_W    = 8;
    localparam int GRAD_W   = 11;
    localparam int GRAD_MAX = 1020;
    localparam int SQ_W     = 20;
    localparam int PROD_W   = 2 * GRAD_W;
    localparam int MED_SQ_W = 2 * PIX_W;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [COL_W-1:0] t_col;

    // read of both line stores, plus write of the newest row at the same column
    typedef struct packed {
        logic en;
        t_col addr;
        t_pix data;
    } t_ls_rd;

    // write of the older row
    typedef struct packed {
        logic en;
        t_col addr;
        t_pix data;
    } t_ls_wr;

endpackage

`default_nettype wire

// ----- rtl/core/semt_line_stores.sv -----
`default_nettype none

module semt_line_stores (
    input  wire logic            i_clk,
    input  semt_pkg::t_ls_rd     i_rd,
    input  semt_pkg::t_ls_wr     i_wr,
    output semt_pkg::t_pix       o_top,
    output semt_pkg::t_pix       o_mid
);
    import semt_pkg::*;

    t_pix mem_a [0:MAX_WIDTH-1];
    t_pix mem_b [0:MAX_WIDTH-1];
    t_pix r_top;
    t_pix r_mid;

    // row above: read old value and write the new pixel at the same column
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_mid            <= mem_a[i_rd.addr];
            mem_a[i_rd.addr] <= i_rd.data;
        end
    end

    // row two above: read at accept, written when the beat leaves the read stage
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_top <= mem_b[i_rd.addr];
        end
        if (i_wr.en) begin
            mem_b[i_wr.addr] <= i_wr.data;
        end
    end

    assign o_top = r_top;
    assign o_mid = r_mid;

endmodule

`default_nettype wire

// ----- rtl/core/sobel_edge_median_threshold.sv -----
`default_nettype none

// Streaming 3x3 Sobel edge detector with a median-of-window threshold. Pixels
// enter in raster order, one per clock while o_in_ready is high; the block
// counts column and row itself from frame_width (clamped to 3..2048) and
// frame_height (at least 3). Only interior pixels give a result: edge flag,
// both gradients, the window median and a flag on the last interior pixel of
// the frame. The pipeline is five registers deep (line store read, window,
// row/column sort and gradients, squares and median, result), and one pixel
// per clock is sustained while the output is not stalled; the line stores are
// read once and written once per pixel. Configuration writes are always taken
// and act at once; they belong between frames. Line stores are not cleared
// after reset and need no clearing time.
module sobel_edge_median_threshold (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [semt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [semt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [semt_pkg::PIX_W-1:0]      i_pixel,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic                                 o_edge_res,
    output logic signed [semt_pkg::GRAD_W-1:0]   o_grad_x,
    output logic signed [semt_pkg::GRAD_W-1:0]   o_grad_y,
    output logic [semt_pkg::PIX_W-1:0]           o_median_level,
    output logic                                 o_frame_last
);
    import semt_pkg::*;

    // compare-swap network, result packed as {high, middle, low}
    function automatic logic [3*PIX_W-1:0] sort3(input t_pix a, input t_pix b, input t_pix c);
        t_pix hi;
        t_pix mi;
        t_pix lo;
        t_pix tmp;
        hi = a;
        mi = b;
        lo = c;
        if (hi < mi) begin
            tmp = hi; hi = mi; mi = tmp;
        end
        if (hi < lo) begin
            tmp = hi; hi = lo; lo = tmp;
        end
        if (mi < lo) begin
            tmp = mi; mi = lo; lo = tmp;
        end
        return {hi, mi, lo};
    endfunction

    // configuration registers
    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;

    // frame position
    t_col            r_col;
    logic [FH_W-1:0] r_row;
    t_col            n_col;
    logic [FH_W-1:0] n_row;

    // stage 1: line store read
    logic r_s1_v;
    logic r_s1_emit;
    logic r_s1_last;
    t_pix r_s1_px;
    t_col r_s1_col;
    t_pix top_px;
    t_pix mid_px;

    // stage 2: window
    logic r_s2_v;
    logic r_s2_last;
    t_pix r_win [0:8];

    // stage 3: gradients and sorted diagonal
    logic                     r_s3_v;
    logic                     r_s3_last;
    logic signed [GRAD_W-1:0] r_s3_gx;
    logic signed [GRAD_W-1:0] r_s3_gy;
    t_pix                     r_s3_d [0:2];

    // stage 4: squares and median
    logic                     r_s4_v;
    logic                     r_s4_last;
    logic signed [GRAD_W-1:0] r_s4_gx;
    logic signed [GRAD_W-1:0] r_s4_gy;
    logic [SQ_W-1:0]          r_s4_sqx;
    logic [SQ_W-1:0]          r_s4_sqy;
    t_pix                     r_s4_med;

    // result register
    logic                     r_o_v;
    logic                     r_o_edge;
    logic signed [GRAD_W-1:0] r_o_gx;
    logic signed [GRAD_W-1:0] r_o_gy;
    t_pix                     r_o_med;
    logic                     r_o_last;

    // stage enables and handshakes
    logic en_o;
    logic en_4;
    logic en_3;
    logic en_2;
    logic en_1;
    logic in_acc;
    logic s1_adv;

    assign en_o   = !r_o_v || i_out_ready;
    assign en_4   = !r_s4_v || en_o;
    assign en_3   = !r_s3_v || en_4;
    assign en_2   = !r_s2_v || en_3;
    assign en_1   = !r_s1_v || en_2;
    assign in_acc = i_in_valid && en_1;
    assign s1_adv = r_s1_v && en_2;

    assign o_in_ready  = en_1;
    assign o_cfg_ready = 1'b1;

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_W'(FW_RESET);
            r_frame_height <= FH_W'(FH_RESET);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // effective frame size
    logic [CNT_W-1:0] fw_ext;
    logic [CNT_W-1:0] w_eff;
    logic [FH_W-1:0]  h_eff;

    assign fw_ext = CNT_W'(r_frame_width);
    assign w_eff  = (fw_ext < CNT_W'(MIN_DIM))   ? CNT_W'(MIN_DIM)   :
                    (fw_ext > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : fw_ext;
    assign h_eff  = (r_frame_height < FH_W'(MIN_DIM)) ? FH_W'(MIN_DIM) : r_frame_height;

    // position of this pixel, with wrap of counts left beyond a changed limit
    logic            wrap_c;
    t_col            cur_col;
    logic [FH_W:0]   row_a;
    logic [FH_W-1:0] cur_row;
    logic            cur_emit;
    logic            cur_last;
    logic [CNT_W-1:0] col_inc;
    logic [FH_W:0]   row_inc;

    always_comb begin
        wrap_c   = CNT_W'(r_col) >= w_eff;
        cur_col  = wrap_c ? '0 : r_col;
        row_a    = wrap_c ? ({1'b0, r_row} + 1'b1) : {1'b0, r_row};
        cur_row  = (row_a >= {1'b0, h_eff}) ? '0 : row_a[FH_W-1:0];
        cur_emit = (cur_row >= FH_W'(MIN_DIM - 1)) && (cur_col >= COL_W'(MIN_DIM - 1));
        cur_last = (cur_row == h_eff - 1'b1) && (CNT_W'(cur_col) == w_eff - 1'b1);
        col_inc  = CNT_W'(cur_col) + 1'b1;
        row_inc  = {1'b0, cur_row} + 1'b1;
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[FH_W-1:0];
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = cur_row;
        end
    end

    // frame position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line stores
    t_ls_rd ls_rd;
    t_ls_wr ls_wr;

    assign ls_rd = '{en: in_acc, addr: cur_col, data: i_pixel};
    assign ls_wr = '{en: s1_adv, addr: r_s1_col, data: mid_px};

    semt_line_stores u_line_stores (
        .i_clk (i_clk),
        .i_rd  (ls_rd),
        .i_wr  (ls_wr),
        .o_top (top_px),
        .o_mid (mid_px)
    );

    // valid flags of the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (en_1) begin
                r_s1_v <= i_in_valid;
            end
            if (en_2) begin
                r_s2_v <= r_s1_v && r_s1_emit;
            end
            if (en_3) begin
                r_s3_v <= r_s2_v;
            end
            if (en_4) begin
                r_s4_v <= r_s3_v;
            end
            if (en_o) begin
                r_o_v <= r_s4_v;
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_emit <= cur_emit;
            r_s1_last <= cur_last;
            r_s1_px   <= i_pixel;
            r_s1_col  <= cur_col;
        end
    end

    // window shifts one column for every pixel, emitted or not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_adv) begin
            for (int r = 0; r < 3; r++) begin
                r_win[3*r]   <= r_win[3*r+1];
                r_win[3*r+1] <= r_win[3*r+2];
            end
            r_win[2] <= top_px;
            r_win[5] <= mid_px;
            r_win[8] <= r_s1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_last <= r_s1_last;
        end
    end

    // sobel sums and row / column sort of the window
    logic [PIX_W+1:0]         sum_l;
    logic [PIX_W+1:0]         sum_r;
    logic [PIX_W+1:0]         sum_t;
    logic [PIX_W+1:0]         sum_b;
    logic signed [GRAD_W-1:0] n_gx;
    logic signed [GRAD_W-1:0] n_gy;
    t_pix                     g_row [0:2][0:2];
    t_pix                     g_col [0:2][0:2];

    always_comb begin
        sum_l = {2'b0, r_win[0]} + {1'b0, r_win[3], 1'b0} + {2'b0, r_win[6]};
        sum_r = {2'b0, r_win[2]} + {1'b0, r_win[5], 1'b0} + {2'b0, r_win[8]};
        sum_t = {2'b0, r_win[0]} + {1'b0, r_win[1], 1'b0} + {2'b0, r_win[2]};
        sum_b = {2'b0, r_win[6]} + {1'b0, r_win[7], 1'b0} + {2'b0, r_win[8]};
        n_gx  = $signed({1'b0, sum_l}) - $signed({1'b0, sum_r});
        n_gy  = $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});
        for (int r = 0; r < 3; r++) begin
            {g_row[r][0], g_row[r][1], g_row[r][2]} =
                sort3(r_win[3*r], r_win[3*r+1], r_win[3*r+2]);
        end
        for (int c = 0; c < 3; c++) begin
            {g_col[0][c], g_col[1][c], g_col[2][c]} =
                sort3(g_row[0][c], g_row[1][c], g_row[2][c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_3) begin
            r_s3_last <= r_s2_last;
            r_s3_gx   <= n_gx;
            r_s3_gy   <= n_gy;
            r_s3_d[0] <= g_col[0][2];
            r_s3_d[1] <= g_col[1][1];
            r_s3_d[2] <= g_col[2][0];
        end
    end

    // squared gradients and median from the diagonal
    logic signed [PROD_W-1:0] sq_x_full;
    logic signed [PROD_W-1:0] sq_y_full;
    logic [3*PIX_W-1:0]       diag_sorted;

    assign sq_x_full   = r_s3_gx * r_s3_gx;
    assign sq_y_full   = r_s3_gy * r_s3_gy;
    assign diag_sorted = sort3(r_s3_d[0], r_s3_d[1], r_s3_d[2]);

    always_ff @(posedge i_clk) begin
        if (en_4) begin
            r_s4_last <= r_s3_last;
            r_s4_gx   <= r_s3_gx;
            r_s4_gy   <= r_s3_gy;
            r_s4_sqx  <= sq_x_full[SQ_W-1:0];
            r_s4_sqy  <= sq_y_full[SQ_W-1:0];
            r_s4_med  <= diag_sorted[2*PIX_W-1:PIX_W];
        end
    end

    // edge when squared magnitude exceeds squared median
    logic [MED_SQ_W-1:0] med_sq;
    logic [SQ_W:0]       mag_sq;
    logic                n_edge;

    assign med_sq = r_s4_med * r_s4_med;
    assign mag_sq = {1'b0, r_s4_sqx} + {1'b0, r_s4_sqy};
    assign n_edge = mag_sq > (SQ_W + 1)'(med_sq);

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_o_edge <= n_edge;
            r_o_gx   <= r_s4_gx;
            r_o_gy   <= r_s4_gy;
            r_o_med  <= r_s4_med;
            r_o_last <= r_s4_last;
        end
    end

    assign o_out_valid    = r_o_v;
    assign o_edge_res     = r_o_edge;
    assign o_grad_x       = r_o_gx;
    assign o_grad_y       = r_o_gy;
    assign o_median_level = r_o_med;
    assign o_frame_last   = r_o_last;

endmodule

`default_nettype wire

// ----- rtl/core/semt_checker.sv -----
`default_nettype none

`include "sobel_edge_median_threshold_defines.svh"

module semt_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_cfg_valid,
    input wire logic                            o_cfg_ready,
    input wire logic [semt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input wire logic [semt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_ready,
    input wire logic [semt_pkg::PIX_W-1:0]      i_pixel,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_ready,
    input wire logic                            o_edge_res,
    input wire logic signed [semt_pkg::GRAD_W-1:0] o_grad_x,
    input wire logic signed [semt_pkg::GRAD_W-1:0] o_grad_y,
    input wire logic [semt_pkg::PIX_W-1:0]      o_median_level,
    input wire logic                            o_frame_last
);
    import semt_pkg::*;

    // a stalled result beat keeps its valid and its fields
    `SEMT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_edge_res) && $stable(o_grad_x) && $stable(o_grad_y) && $stable(o_median_level) && $stable(o_frame_last), "stalled result beat changed")

    // flat window never counts as an edge
    `SEMT_ASSERT_IMP(a_flat_no_edge, i_clk, i_rst_n, o_out_valid && (o_grad_x == '0) && (o_grad_y == '0), !o_edge_res, "edge flagged with zero gradients")

    // any gradient above a zero threshold is an edge
    `SEMT_ASSERT_IMP(a_zero_med_edge, i_clk, i_rst_n, o_out_valid && (o_median_level == '0) && ((o_grad_x != '0) || (o_grad_y != '0)), o_edge_res, "missed edge at zero median")

    // gradients stay within the range of a 3x3 sobel kernel on 8-bit pixels
    `SEMT_ASSERT_IMP(a_grad_range, i_clk, i_rst_n, o_out_valid, (o_grad_x >= -GRAD_MAX) && (o_grad_x <= GRAD_MAX) && (o_grad_y >= -GRAD_MAX) && (o_grad_y <= GRAD_MAX), "gradient out of range")

endmodule

bind sobel_edge_median_threshold semt_checker u_semt_checker (.*);

`default_nettype wire
